>>> src/clcd_pkg.sv
package clcd_pkg;

  // Width of the tick counter and of the timing registers.
  localparam int unsigned COUNTER_BITS = 20;

  // Request kinds carried by the action field.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_CURSOR = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PULSE = 2'd0,
    REG_HOLD  = 2'd1,
    REG_BOOT  = 2'd2,
    REG_SWAP  = 2'd3
  } cfg_reg_t;

  // Reset values of the timing registers.
  localparam logic [COUNTER_BITS-1:0] PULSE_RESET = COUNTER_BITS'(50);
  localparam logic [COUNTER_BITS-1:0] HOLD_RESET  = COUNTER_BITS'(2000);
  localparam logic [COUNTER_BITS-1:0] BOOT_RESET  = COUNTER_BITS'(50000);

  // Number of bytes in the power-up sequence; a step of this value means done.
  localparam logic [2:0] INIT_DONE = 3'd7;

  // Command bits used by a cursor move.
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW1_BASE    = 8'h40;

  // Power-up sequence: two upper-nibble-only 0x30 writes, then full bytes.
  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd0:    b = 8'h30;
      3'd1:    b = 8'h30;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h28;
      3'd4:    b = 8'h0C;
      3'd5:    b = 8'h01;
      default: b = 8'h0F;
    endcase
    return b;
  endfunction

endpackage

>>> src/char_lcd_nibble_interface_unit.sv
// Character LCD controller for a four-bit bus.
// Request channel (req_valid / req_stall): each word is a tick, a command
// byte, a text byte or a cursor move. Ticks are the only sense of time; every
// wait is counted in ticks. Requests other than ticks are refused while the
// controller is busy, which the result shows with accepted low.
// Result channel (res_valid / res_stall): exactly one word per request word,
// giving the pin levels, the idle flag and the accepted flag as they stand
// after that request has been applied.
// The result comes registered in the cycle after its request; one request
// word can be taken every cycle unless the receiver stalls; the state update
// and the result register sit on either side of a single stage of logic.
// When the receiver stalls, the held result stays put and req_stall rises so
// that no further request is taken until the result has gone.
// Configuration (cfg_valid / cfg_ready) is always ready and should be written
// only while the controller is idle.
// After reset the controller waits boot_ticks ticks, then sends the power-up
// sequence before it first reports idle.
module char_lcd_nibble_interface_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            action,
  input  logic [7:0]                            byte_value,
  input  logic                                  end_of_text,
  input  logic [5:0]                            column,
  input  logic                                  row,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic [3:0]                            bus_nibble,
  output logic                                  enable_pin,
  output logic                                  select_pin,
  output logic                                  ready_res,
  output logic                                  accepted,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [clcd_pkg::COUNTER_BITS-1:0]     cfg_data
);
  import clcd_pkg::*;

  typedef enum logic [2:0] {
    PH_BOOT,
    PH_PULSE,
    PH_HOLD,
    PH_BYTE_HOLD,
    PH_EXTRA_HOLD,
    PH_IDLE
  } phase_t;

  // Configuration registers.
  logic [COUNTER_BITS-1:0] pulse_ticks, hold_ticks, boot_ticks;
  logic                    swap_upper_bits;

  // Controller state.
  phase_t                  phase, phase_next;
  logic [COUNTER_BITS-1:0] tick_count, tick_count_next;
  logic [2:0]              init_step, init_step_next;
  logic [7:0]              held_byte, held_byte_next;
  logic                    low_half_next, low_half_next_next;
  logic [3:0]              nibble_reg, nibble_reg_next;
  logic                    enable_reg, enable_reg_next;
  logic                    select_reg, select_reg_next;
  logic                    drop_select, drop_select_next;

  logic                    req_take;
  logic                    acc_next;
  logic [COUNTER_BITS-1:0] limit_raw, limit;
  logic [COUNTER_BITS:0]   count_inc;
  logic                    count_done;
  logic [2:0]              step_inc;
  logic [7:0]              start_val;
  logic                    start_en, start_upper;
  logic [3:0]              pin_levels;

  assign cfg_ready = 1'b1;

  // A request word is taken whenever the result register can be refilled.
  assign req_stall = res_valid & res_stall;
  assign req_take  = req_valid & ~req_stall;

  // Wait limit for the current phase; a zero setting counts as one tick.
  always_comb begin
    unique case (phase)
      PH_BOOT:  limit_raw = boot_ticks;
      PH_PULSE: limit_raw = pulse_ticks;
      default:  limit_raw = hold_ticks;
    endcase
    limit      = (limit_raw == '0) ? COUNTER_BITS'(1) : limit_raw;
    count_inc  = {1'b0, tick_count} + (COUNTER_BITS+1)'(1);
    count_done = count_inc >= {1'b0, limit};
  end

  // Next state for one request word.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    init_step_next     = init_step;
    held_byte_next     = held_byte;
    low_half_next_next = low_half_next;
    nibble_reg_next    = nibble_reg;
    enable_reg_next    = enable_reg;
    select_reg_next    = select_reg;
    drop_select_next   = drop_select;
    acc_next           = 1'b0;
    start_en           = 1'b0;
    start_upper        = 1'b0;
    start_val          = byte_value;
    step_inc           = init_step + 3'd1;

    if (action_t'(action) == ACT_TICK) begin
      if (phase != PH_IDLE) begin
        tick_count_next = count_done ? '0 : count_inc[COUNTER_BITS-1:0];
      end
      unique case (phase)
        PH_BOOT: begin
          if (count_done) begin
            init_step_next = 3'd0;
            start_en       = 1'b1;
            start_upper    = 1'b1;
            start_val      = init_byte(3'd0);
          end
        end
        PH_PULSE: begin
          if (count_done) begin
            enable_reg_next = 1'b0;
            phase_next      = PH_HOLD;
          end
        end
        PH_HOLD: begin
          if (count_done) begin
            if (low_half_next) begin
              low_half_next_next = 1'b0;
              nibble_reg_next    = held_byte[3:0];
              enable_reg_next    = 1'b1;
              phase_next         = PH_PULSE;
            end else begin
              phase_next = PH_BYTE_HOLD;
            end
          end
        end
        PH_BYTE_HOLD, PH_EXTRA_HOLD: begin
          if (count_done) begin
            if (phase == PH_BYTE_HOLD && init_step == 3'd0) begin
              // The first init write gets a second byte hold for settling.
              phase_next = PH_EXTRA_HOLD;
            end else if (init_step != INIT_DONE) begin
              init_step_next = step_inc;
              if (step_inc != INIT_DONE) begin
                start_en    = 1'b1;
                start_upper = (step_inc == 3'd1);
                start_val   = init_byte(step_inc);
              end else begin
                phase_next = PH_IDLE;
              end
            end else begin
              if (drop_select) begin
                select_reg_next  = 1'b0;
                drop_select_next = 1'b0;
              end
              phase_next = PH_IDLE;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end else if (phase == PH_IDLE) begin
      acc_next = 1'b1;
      start_en = 1'b1;
      if (action_t'(action) == ACT_TEXT) begin
        select_reg_next  = 1'b1;
        drop_select_next = end_of_text;
      end else begin
        select_reg_next  = 1'b0;
        drop_select_next = 1'b0;
        if (action_t'(action) == ACT_CURSOR) begin
          start_val = CMD_SET_ADDR | (row ? ROW1_BASE : 8'h00) | {2'b00, column};
        end
      end
    end

    // Load a byte and raise enable with its upper nibble.
    if (start_en) begin
      held_byte_next     = start_val;
      low_half_next_next = ~start_upper;
      nibble_reg_next    = start_val[7:4];
      enable_reg_next    = 1'b1;
      phase_next         = PH_PULSE;
      tick_count_next    = '0;
    end
  end

  // Board routing may swap data bits 2 and 3.
  assign pin_levels = swap_upper_bits ?
    {nibble_reg_next[2], nibble_reg_next[3], nibble_reg_next[1:0]} : nibble_reg_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks     <= PULSE_RESET;
      hold_ticks      <= HOLD_RESET;
      boot_ticks      <= BOOT_RESET;
      swap_upper_bits <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PULSE: pulse_ticks     <= cfg_data;
        REG_HOLD:  hold_ticks      <= cfg_data;
        REG_BOOT:  boot_ticks      <= cfg_data;
        REG_SWAP:  swap_upper_bits <= cfg_data[0];
      endcase
    end
  end

  // Controller state advances once per request word taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BOOT;
      tick_count    <= '0;
      init_step     <= 3'd0;
      held_byte     <= 8'h00;
      low_half_next <= 1'b0;
      nibble_reg    <= 4'h0;
      enable_reg    <= 1'b0;
      select_reg    <= 1'b0;
      drop_select   <= 1'b0;
    end else if (req_take) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      init_step     <= init_step_next;
      held_byte     <= held_byte_next;
      low_half_next <= low_half_next_next;
      nibble_reg    <= nibble_reg_next;
      enable_reg    <= enable_reg_next;
      select_reg    <= select_reg_next;
      drop_select   <= drop_select_next;
    end
  end

  // Result register: valid flag is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      bus_nibble <= pin_levels;
      enable_pin <= enable_reg_next;
      select_pin <= select_reg_next;
      ready_res  <= (phase_next == PH_IDLE);
      accepted   <= acc_next;
    end
  end

endmodule

>>> src/clcd_checker.sv
module clcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [3:0] bus_nibble,
  input logic       enable_pin,
  input logic       ready_res,
  input logic       accepted
);

  // No result word survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result word stays offered.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result word keeps its pin levels.
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(bus_nibble))
    else $error("pin levels changed while stalled");

  // A taken request starts a byte: enable high and no longer idle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    res_valid && accepted |-> enable_pin && !ready_res)
    else $error("accepted request did not start a byte");

  // The controller is never idle with enable high.
  a_idle_no_enable: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(enable_pin && ready_res))
    else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface_unit clcd_checker u_clcd_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .bus_nibble (bus_nibble),
  .enable_pin (enable_pin),
  .ready_res  (ready_res),
  .accepted   (accepted)
);
